### rtl/core/cbor_hbe_pkg.sv
// Shared types, constants and helpers for the CBOR head byte emitter.
// Used by every module under rtl/core; depends on nothing else.

package cbor_hbe_pkg;

  localparam int CAP_W       = 16;
  localparam int POS_W       = 17;
  localparam int VAL_W       = 64;
  localparam int BYTE_W      = 8;
  localparam int GROUP_BYTES = 9;
  localparam int CNT_W       = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam int DEFAULT_MAX_CAPACITY = 65535;

  localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

  // Register byte addresses.
  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  // Additional info codes of the initial byte.
  localparam logic [4:0] AI_IMM_MAX = 5'd23;
  localparam logic [4:0] AI_ARG1    = 5'd24;
  localparam logic [4:0] AI_ARG2    = 5'd25;
  localparam logic [4:0] AI_ARG4    = 5'd26;
  localparam logic [4:0] AI_ARG8    = 5'd27;

  typedef enum logic [1:0] {
    FUNC_HEAD = 2'd0,
    FUNC_RUN  = 2'd1,
    FUNC_DATA = 2'd2,
    FUNC_NONE = 2'd3
  } func_t;

  // All result beats caused by one item, handed from the encoder to the serializer.
  typedef struct packed {
    logic [CNT_W-1:0]              count;
    logic [GROUP_BYTES*BYTE_W-1:0] bytes;
    logic [POS_W-1:0]              pos;
    logic                          stored_first;
    logic                          stored_rest;
    logic                          error_first;
    logic                          error_rest;
  } group_t;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] pos);
    sat_inc = (pos == POS_MAX) ? POS_MAX : pos + POS_W'(1);
  endfunction

endpackage

### rtl/core/cbor_head_byte_emitter.sv
// CBOR head byte emitter, top level. Depends on cbor_hbe_pkg, cbor_hbe_cfg,
// cbor_hbe_encode and cbor_hbe_serial.
//
// Use: items enter on the in_valid/in_stall channel (func, major, value,
// data_byte); every encoded byte leaves as one beat on out_valid/out_stall
// with its buffer position, a stored flag, a last flag and the sticky error.
// A head item gives one to nine beats, a data byte gives one beat, and a
// raw-run open (or an unused func code, or a head after an error) gives none.
// An accepted item is registered in the input register and evaluated in one pass;
// its group is then loaded into the output register, which offers its first beat.
// Throughput: the output register sends one beat per cycle while the receiver does
// not stall, so data bytes flow one per cycle; a head holds the input while its
// beats go out, and items without beats pass one per cycle each.
// The input register lets the next item be taken while the current group
// still waits on the output. When the receiver stalls, the current beat holds
// and the input stalls once the input register is full.
// Reset clears the length, run state, error flag and both valid stages, and
// sets the capacity register to its maximum. The user must write the capacity
// through the APB-style port only while the block is idle; the block does not enforce it.

module cbor_head_byte_emitter #(
  parameter int MAX_CAPACITY = cbor_hbe_pkg::DEFAULT_MAX_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbor_hbe_pkg::PADDR_W-1:0] paddr,
  input  logic [cbor_hbe_pkg::PDATA_W-1:0] pwdata,
  output logic [cbor_hbe_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       func,
  input  logic [2:0]                       major,
  input  logic [cbor_hbe_pkg::VAL_W-1:0]   value,
  input  logic [7:0]                       data_byte,
  // Output channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_byte,
  output logic [cbor_hbe_pkg::POS_W-1:0]   out_pos,
  output logic                             out_stored,
  output logic                             out_last,
  output logic                             out_error
);
  import cbor_hbe_pkg::*;

  logic [CAP_W-1:0] capacity;
  logic             group_valid;
  logic             group_take;
  group_t           group;

  // Capacity register behind the configuration port.
  cbor_hbe_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // The encoder owns the length, run and error state. It evaluates the held
  // item in one pass and offers all of its beats as a single group.
  cbor_hbe_encode #(
    .MAX_CAPACITY (MAX_CAPACITY)
  ) u_encode (
    .clk         (clk),
    .rst         (rst),
    .capacity    (capacity),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .major       (major),
    .value       (value),
    .data_byte   (data_byte),
    .group_take  (group_take),
    .group_valid (group_valid),
    .group       (group)
  );

  // The serializer takes a new group as its previous last beat leaves, so
  // back-to-back single-beat groups go out one per cycle while the receiver does not stall.
  cbor_hbe_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .group_valid (group_valid),
    .group       (group),
    .group_take  (group_take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .out_pos     (out_pos),
    .out_stored  (out_stored),
    .out_last    (out_last),
    .out_error   (out_error)
  );

endmodule

### rtl/core/cbor_hbe_cfg.sv
// APB-style configuration register file holding the buffer capacity.
// Depends on cbor_hbe_pkg.

module cbor_hbe_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbor_hbe_pkg::PADDR_W-1:0] paddr,
  input  logic [cbor_hbe_pkg::PDATA_W-1:0] pwdata,
  output logic [cbor_hbe_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output logic [cbor_hbe_pkg::CAP_W-1:0]   capacity
);
  import cbor_hbe_pkg::*;

  logic hit;

  assign hit    = (paddr == ADDR_CAPACITY);
  assign pready = 1'b1;
  assign prdata = hit ? PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

endmodule

### rtl/core/cbor_hbe_encode.sv
// Input register, encoder state and single-pass head/run/data evaluation.
// Produces a group of result beats per data item and error-free head. Depends on cbor_hbe_pkg.

module cbor_hbe_encode #(
  parameter int MAX_CAPACITY = cbor_hbe_pkg::DEFAULT_MAX_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cbor_hbe_pkg::CAP_W-1:0] capacity,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     func,
  input  logic [2:0]                     major,
  input  logic [cbor_hbe_pkg::VAL_W-1:0] value,
  input  logic [7:0]                     data_byte,
  input  logic                           group_take,
  output logic                           group_valid,
  output cbor_hbe_pkg::group_t           group
);
  import cbor_hbe_pkg::*;

  // Held item
  logic              item_valid;
  func_t             item_func;
  logic [2:0]        item_major;
  logic [VAL_W-1:0]  item_value;
  logic [BYTE_W-1:0] item_data;

  // Encoder state
  logic [POS_W-1:0] write_length;
  logic             overflow_flag;
  logic             run_fits;
  logic [POS_W-1:0] run_position;

  logic             accept;
  logic             advance;
  logic             has_results;
  logic [CAP_W-1:0] cap_small;
  logic [POS_W-1:0] cap;

  logic [4:0]       ai;
  logic [CNT_W-1:0] nargs;
  logic [VAL_W-1:0] arg_vec;
  logic             ok0;
  logic             ok1;
  logic             err0;
  logic             err1;
  logic [POS_W-1:0] base;
  logic [POS_W:0]   sum_arg;
  logic [POS_W-1:0] wl_head;

  logic             run_hi_zero;
  logic [POS_W:0]   sum_run;
  logic             ok_run;
  logic [POS_W-1:0] wl_run;
  logic             ok_data;

  // Effective capacity is the smaller of the register and the build limit.
  assign cap_small = (capacity < CAP_W'(MAX_CAPACITY)) ? capacity : CAP_W'(MAX_CAPACITY);
  assign cap       = POS_W'(cap_small);

  // Head: argument size and initial byte.
  always_comb begin
    if (item_value <= VAL_W'(AI_IMM_MAX)) begin
      ai    = item_value[4:0];
      nargs = CNT_W'(0);
    end else if (item_value[VAL_W-1:8] == '0) begin
      ai    = AI_ARG1;
      nargs = CNT_W'(1);
    end else if (item_value[VAL_W-1:16] == '0) begin
      ai    = AI_ARG2;
      nargs = CNT_W'(2);
    end else if (item_value[VAL_W-1:32] == '0) begin
      ai    = AI_ARG4;
      nargs = CNT_W'(4);
    end else begin
      ai    = AI_ARG8;
      nargs = CNT_W'(8);
    end
  end

  // Left-align the argument so its most significant byte goes out first.
  always_comb begin
    case (nargs)
      CNT_W'(1): arg_vec = {item_value[7:0], 56'd0};
      CNT_W'(2): arg_vec = {item_value[15:0], 48'd0};
      CNT_W'(4): arg_vec = {item_value[31:0], 32'd0};
      default:   arg_vec = item_value;
    endcase
  end

  assign ok0     = (write_length < cap);
  assign err0    = !ok0;
  assign base    = sat_inc(write_length);
  assign sum_arg = {1'b0, base} + (POS_W+1)'(nargs);
  assign ok1     = (sum_arg <= {1'b0, cap});
  assign err1    = err0 || !ok1;
  assign wl_head = (nargs == '0) ? base :
                   ((sum_arg > {1'b0, POS_MAX}) ? POS_MAX : sum_arg[POS_W-1:0]);

  // Raw run reservation.
  assign run_hi_zero = (item_value[VAL_W-1:POS_W] == '0);
  assign sum_run     = {1'b0, write_length} + {1'b0, item_value[POS_W-1:0]};
  assign ok_run      = run_hi_zero && (sum_run <= {1'b0, cap});
  assign wl_run      = (!run_hi_zero || (sum_run > {1'b0, POS_MAX})) ? POS_MAX
                                                                       : sum_run[POS_W-1:0];

  assign ok_data = run_fits && (run_position < cap);

  always_comb begin
    group = '0;
    if (item_func == FUNC_HEAD) begin
      group.count        = nargs + CNT_W'(1);
      group.bytes        = {item_major, ai, arg_vec};
      group.pos          = write_length;
      group.stored_first = ok0;
      group.stored_rest  = ok1;
      group.error_first  = err0;
      group.error_rest   = err1;
    end else begin
      group.count        = CNT_W'(1);
      group.bytes        = {item_data, 64'd0};
      group.pos          = run_position;
      group.stored_first = ok_data;
      group.stored_rest  = ok_data;
      group.error_first  = overflow_flag;
      group.error_rest   = overflow_flag;
    end
  end

  assign has_results = ((item_func == FUNC_HEAD) && !overflow_flag) || (item_func == FUNC_DATA);
  assign group_valid = item_valid && has_results;
  assign advance     = item_valid && (!has_results || group_take);
  assign in_stall    = item_valid && !advance;
  assign accept      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_func  <= func_t'(func);
      item_major <= major;
      item_value <= value;
      item_data  <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_length  <= '0;
      overflow_flag <= 1'b0;
      run_fits      <= 1'b0;
      run_position  <= '0;
    end else if (advance) begin
      case (item_func)
        FUNC_HEAD: begin
          if (!overflow_flag) begin
            run_fits      <= 1'b0;
            write_length  <= wl_head;
            overflow_flag <= err0 || ((nargs != '0) && !ok1);
          end
        end
        FUNC_RUN: begin
          if (!overflow_flag) begin
            overflow_flag <= !ok_run;
            run_fits      <= ok_run;
            run_position  <= write_length;
            write_length  <= wl_run;
          end
        end
        FUNC_DATA: begin
          run_position <= sat_inc(run_position);
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTH
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |=> overflow_flag)
    else $error("overflow error cleared without reset");

  a_head_closes_run: assert property (@(posedge clk) disable iff (rst)
    (advance && (item_func == FUNC_HEAD) && !overflow_flag) |=> !run_fits)
    else $error("head did not close the open raw run");
`endif

endmodule

### rtl/core/cbor_hbe_serial.sv
// Output serializer: holds one group and sends its bytes one beat per cycle
// while the receiver does not stall. Depends on cbor_hbe_pkg.

module cbor_hbe_serial (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           group_valid,
  input  cbor_hbe_pkg::group_t           group,
  output logic                           group_take,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic [cbor_hbe_pkg::POS_W-1:0] out_pos,
  output logic                           out_stored,
  output logic                           out_last,
  output logic                           out_error
);
  import cbor_hbe_pkg::*;

  logic [CNT_W-1:0]              cnt;
  logic                          first;
  logic [GROUP_BYTES*BYTE_W-1:0] bytes;
  logic [POS_W-1:0]              pos;
  logic                          stored_first;
  logic                          stored_rest;
  logic                          error_first;
  logic                          error_rest;
  logic                          beat_done;

  assign out_valid  = (cnt != '0);
  assign out_last   = (cnt == CNT_W'(1));
  assign out_byte   = bytes[GROUP_BYTES*BYTE_W-1 -: BYTE_W];
  assign out_pos    = pos;
  assign out_stored = first ? stored_first : stored_rest;
  assign out_error  = first ? error_first : error_rest;

  assign beat_done  = out_valid && !out_stall;
  assign group_take = !out_valid || (beat_done && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      first <= 1'b0;
    end else if (group_take) begin
      cnt   <= group_valid ? group.count : '0;
      first <= 1'b1;
    end else if (beat_done) begin
      cnt   <= cnt - CNT_W'(1);
      first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (group_take && group_valid) begin
      bytes        <= group.bytes;
      pos          <= group.pos;
      stored_first <= group.stored_first;
      stored_rest  <= group.stored_rest;
      error_first  <= group.error_first;
      error_rest   <= group.error_rest;
    end else if (beat_done) begin
      bytes <= {bytes[GROUP_BYTES*BYTE_W-BYTE_W-1:0], BYTE_W'(0)};
      pos   <= sat_inc(pos);
    end
  end

`ifndef SYNTH
  a_hold_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(cnt)))
    else $error("beat count moved while the receiver stalled");

  a_group_continues: assert property (@(posedge clk) disable iff (rst)
    (beat_done && !out_last) |=> (out_valid && !first))
    else $error("group ended before its last beat");

  a_group_loads: assert property (@(posedge clk) disable iff (rst)
    (group_take && group_valid) |=> (out_valid && first))
    else $error("taken group did not appear on the output");
`endif

endmodule

### rtl/core/cbor_hbe_emitter.sv
// Holds no logic of its own; the block is assembled in cbor_head_byte_emitter
// from cbor_hbe_cfg, cbor_hbe_encode and cbor_hbe_serial. Depends on nothing.

### tb/cbor_hbe_sb_pkg.sv
// Scoreboard for the CBOR head byte emitter testbench: predicts the byte beats
// of every accepted item and checks the beats that leave the block.
// Depends on cbor_hbe_pkg only.

package cbor_hbe_sb_pkg;
  import cbor_hbe_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] enc_byte;
    logic [POS_W-1:0]  pos;
    logic              stored;
    logic              last;
    logic              error;
  } beat_t;

  class cbor_byte_scoreboard;
    logic [CAP_W-1:0] capacity;
    logic [POS_W-1:0] length;
    logic             overflow;
    logic             run_fits;
    logic [POS_W-1:0] run_pos;
    beat_t            expected_beats[$];
    int               fail_count;
    int               items_noted;
    int               beats_checked;
    int               beats_stored;

    function new();
      capacity      = CAP_RESET;
      length        = '0;
      overflow      = 1'b0;
      run_fits      = 1'b0;
      run_pos       = '0;
      fail_count    = 0;
      items_noted   = 0;
      beats_checked = 0;
      beats_stored  = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = cap;
    endfunction

    // Free bytes left below the capacity; negative once the length is past it.
    function int room();
      return int'(capacity) - int'(length);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void note_failure(string what);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH: %s", what);
    endfunction

    function bit fits(logic [POS_W-1:0] at, logic [VAL_W-1:0] n);
      logic [POS_W-1:0] cap;
      cap = POS_W'(capacity);
      if (at > cap) return 1'b0;
      return n <= VAL_W'(cap - at);
    endfunction

    function logic [POS_W-1:0] sat_add(logic [POS_W-1:0] at, logic [VAL_W-1:0] n);
      logic [VAL_W:0] sum;
      logic [VAL_W:0] wide_at;
      wide_at = at;
      sum     = {1'b0, n} + wide_at;
      return (sum > POS_MAX) ? POS_MAX : sum[POS_W-1:0];
    endfunction

    function void push_beat(logic [BYTE_W-1:0] b, logic [POS_W-1:0] at, bit ok, bit is_last);
      expected_beats.push_back('{enc_byte: b, pos: at, stored: ok, last: is_last,
                                 error: overflow});
    endfunction

    function void note_item(func_t f, logic [2:0] major_type, logic [VAL_W-1:0] v,
                            logic [BYTE_W-1:0] d);
      logic [4:0]       info;
      int               nargs;
      logic [POS_W-1:0] base;
      bit               ok;
      if (f != FUNC_NONE) items_noted++;
      case (f)
        FUNC_HEAD: begin
          if (overflow) return;
          run_fits = 1'b0;
          if (v <= VAL_W'(AI_IMM_MAX)) begin
            info  = v[4:0];
            nargs = 0;
          end else if (v[63:8] == '0) begin
            info  = AI_ARG1;
            nargs = 1;
          end else if (v[63:16] == '0) begin
            info  = AI_ARG2;
            nargs = 2;
          end else if (v[63:32] == '0) begin
            info  = AI_ARG4;
            nargs = 4;
          end else begin
            info  = AI_ARG8;
            nargs = 8;
          end
          ok = fits(length, VAL_W'(1));
          if (!ok) overflow = 1'b1;
          push_beat({major_type, info}, length, ok, nargs == 0);
          length = sat_add(length, VAL_W'(1));
          if (nargs > 0) begin
            // The argument bytes are stored all together or not at all.
            base = length;
            ok   = fits(base, VAL_W'(nargs));
            if (!ok) overflow = 1'b1;
            for (int i = 0; i < nargs; i++)
              push_beat(BYTE_W'(v >> (8 * (nargs - 1 - i))), sat_add(base, VAL_W'(i)), ok,
                        i == nargs - 1);
            length = sat_add(base, VAL_W'(nargs));
          end
        end
        FUNC_RUN: begin
          if (overflow) return;
          ok = fits(length, v);
          if (!ok) overflow = 1'b1;
          run_fits = ok;
          run_pos  = length;
          length   = sat_add(length, v);
        end
        FUNC_DATA: begin
          push_beat(d, run_pos, run_fits && (run_pos < POS_W'(capacity)), 1'b1);
          run_pos = sat_add(run_pos, VAL_W'(1));
        end
        default: ;
      endcase
    endfunction

    function string show(beat_t b);
      return $sformatf("byte=%02h pos=%0d stored=%0b last=%0b error=%0b",
                       b.enc_byte, b.pos, b.stored, b.last, b.error);
    endfunction

    function void check_beat(beat_t got);
      beat_t want;
      string diff;
      if (expected_beats.size() == 0) begin
        note_failure({"beat with nothing expected: ", show(got)});
        return;
      end
      want = expected_beats.pop_front();
      beats_checked++;
      if (want.stored) beats_stored++;
      diff = "";
      if (got.enc_byte != want.enc_byte) diff = {diff, " byte"};
      if (got.pos != want.pos) diff = {diff, " pos"};
      if (got.stored != want.stored) diff = {diff, " stored"};
      if (got.last != want.last) diff = {diff, " last"};
      if (got.error != want.error) diff = {diff, " error"};
      if (diff != "")
        note_failure($sformatf("beat %0d differs in%s: expected %s, got %s",
                               beats_checked, diff, show(want), show(got)));
    endfunction
  endclass

endpackage

### tb/cbor_head_byte_emitter_tb.sv
// Self-checking testbench for cbor_head_byte_emitter: directed and random items
// under random idling on both channels, predicted by cbor_hbe_sb_pkg.
// Depends on cbor_hbe_pkg, cbor_hbe_sb_pkg and the block's RTL.

module cbor_head_byte_emitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbor_hbe_pkg::*;
  import cbor_hbe_sb_pkg::*;

  // The limit leaves ample room for the slowest correct run.
  localparam int CYCLE_LIMIT  = 100_000;
  // Drain wait after the last predicted beat; it covers items with no beats.
  localparam int DRAIN_CYCLES = 16;

  typedef enum {END_HEAD_PAST_CAP, END_RUN_TOO_BIG, END_ARGS_PAST_CAP} ending_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [PADDR_W-1:0]  paddr     = '0;
  logic [PDATA_W-1:0]  pwdata    = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [1:0]          func      = FUNC_NONE;
  logic [2:0]          major     = '0;
  logic [VAL_W-1:0]    value     = '0;
  logic [7:0]          data_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic [POS_W-1:0]    out_pos;
  logic                out_stored;
  logic                out_last;
  logic                out_error;

  // Chance, in percent, that a side idles in a given cycle.
  int send_idle_pct = 23;
  int recv_idle_pct = 71;

  cbor_byte_scoreboard sb;

  cbor_head_byte_emitter u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, independent of what the block offers.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Every beat taken from the block is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_beat('{enc_byte: out_byte, pos: out_pos, stored: out_stored,
                      last: out_last, error: out_error});
    end
  end

  // Watchdog: a hung handshake or a missing beat ends the run here.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles with %0d beats still expected", cycles,
             sb.pending());
    $display("Regression FAIL");
    $finish;
  end

  // Offers one item, idling first at the sender's rate, and returns at the edge
  // where the item is taken. in_valid stays high so back-to-back items flow.
  task automatic send_item(input func_t f, input logic [2:0] m, input logic [VAL_W-1:0] v,
                           input logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    major     <= m;
    value     <= v;
    data_byte <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(f, m, v, d);
  endtask

  // Stops the input and waits until every predicted beat has left the block,
  // then gives items without beats time to finish as well.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the capacity register with a setup and an access cycle, then reads
  // it back the same way.
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_CAPACITY;
    pwdata  <= PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_capacity(cap);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[CAP_W-1:0] != cap)
      sb.note_failure($sformatf("capacity read back %0d, written %0d",
                                readback[CAP_W-1:0], cap));
  endtask

  // A head argument from a random size class; max_bytes caps the whole head
  // (initial byte plus argument) so it can be made to fit the space left.
  function automatic logic [VAL_W-1:0] head_value(input int max_bytes);
    int size_class;
    size_class = $urandom_range(4);
    if (max_bytes < 9 && size_class > 3) size_class = 3;
    if (max_bytes < 5 && size_class > 2) size_class = 2;
    if (max_bytes < 3 && size_class > 1) size_class = 1;
    if (max_bytes < 2) size_class = 0;
    case (size_class)
      0: return VAL_W'($urandom_range(23));
      1: return VAL_W'($urandom_range(255, 24));
      2: return VAL_W'($urandom_range(65535, 256));
      3: return VAL_W'($urandom_range(32'hFFFF_FFFF, 32'h1_0000));
      default: return {32'($urandom_range(32'hFFFF_FFFF, 1)), 32'($urandom)};
    endcase
  endfunction

  // Random traffic. Most of it is raw runs followed by their data bytes and
  // heads of every size; the rest is stray data bytes, runs whose byte count
  // is missed by one or two, and the unused func code. With near_edge set,
  // every head and run is sized to fit the space left below the capacity,
  // often filling it exactly, so the length walks right up to the edge.
  task automatic run_random(input int n_items, input bit near_edge);
    int sent;
    int pick;
    int count;
    int extra;
    int room;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      room = sb.room();
      if (pick < 40) begin
        if (near_edge && room < 1) begin
          send_item(FUNC_RUN, 3'($urandom), '0, 8'($urandom));
        end else begin
          send_item(FUNC_HEAD, 3'($urandom), head_value(near_edge ? room : 9), 8'($urandom));
        end
        sent++;
      end else if (pick < 80) begin
        count = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
        if (near_edge) count = ($urandom_range(3) == 0) ? room : count % (room + 1);
        case ($urandom_range(9))
          0: extra = (count > 0) ? -1 : 0;
          1: extra = 1;
          2: extra = 2;
          default: extra = 0;
        endcase
        send_item(FUNC_RUN, 3'($urandom), VAL_W'(count), 8'($urandom));
        repeat (count + extra)
          send_item(FUNC_DATA, 3'($urandom), {32'($urandom), 32'($urandom)}, 8'($urandom));
        sent += 1 + count + extra;
      end else if (pick < 92) begin
        send_item(FUNC_DATA, 3'($urandom), {32'($urandom), 32'($urandom)}, 8'($urandom));
        sent++;
      end else begin
        send_item(FUNC_NONE, 3'($urandom), {32'($urandom), 32'($urandom)}, 8'($urandom));
      end
    end
  endtask

  initial begin
    int      room;
    int      left;
    ending_t ending;
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset leaves the capacity at its maximum; write that extreme explicitly.
    write_capacity(CAP_RESET);

    // Directed part. A data byte before any run is emitted but not stored, and
    // the unused func code is dropped without a beat.
    send_item(FUNC_DATA, 3'd0, '0, 8'h00);
    send_item(FUNC_NONE, 3'd7, '1, 8'hFF);
    // One head per size class, each on both sides of its boundary, across all
    // major types; the last one drives every argument bit high.
    send_item(FUNC_HEAD, 3'd0, 64'd0, 8'h00);
    send_item(FUNC_HEAD, 3'd1, 64'd23, 8'h00);
    send_item(FUNC_HEAD, 3'd2, 64'd24, 8'h00);
    send_item(FUNC_HEAD, 3'd3, 64'hFF, 8'h00);
    send_item(FUNC_HEAD, 3'd4, 64'h100, 8'h00);
    send_item(FUNC_HEAD, 3'd5, 64'hFFFF, 8'h00);
    send_item(FUNC_HEAD, 3'd6, 64'h1_0000, 8'h00);
    send_item(FUNC_HEAD, 3'd7, 64'hFFFF_FFFF, 8'h00);
    send_item(FUNC_HEAD, 3'd0, 64'h1_0000_0000, 8'h00);
    send_item(FUNC_HEAD, 3'd7, '1, 8'h00);
    // A three byte run, filled, then one byte past its end, which still lands
    // in the buffer while the run stays open.
    send_item(FUNC_RUN, 3'd0, 64'd3, 8'h00);
    send_item(FUNC_DATA, 3'd0, '0, 8'hA5);
    send_item(FUNC_DATA, 3'd0, '0, 8'h5A);
    send_item(FUNC_DATA, 3'd0, '0, 8'hFF);
    send_item(FUNC_DATA, 3'd0, '0, 8'h00);
    // A head closes the open run, so the next data byte is not stored.
    send_item(FUNC_HEAD, 3'd4, 64'd2, 8'h00);
    send_item(FUNC_DATA, 3'd0, '0, 8'h11);
    // An empty run, then a full-width head.
    send_item(FUNC_RUN, 3'd0, 64'd0, 8'h00);
    send_item(FUNC_HEAD, 3'd7, 64'h0123_4567_89AB_CDEF, 8'h00);

    // Sender idles little, receiver a lot, full capacity.
    run_random(45, 1'b0);
    wait_idle();

    // Receiver idles little, sender a lot, a random capacity well above the
    // length so that nothing overflows yet.
    send_idle_pct = 71;
    recv_idle_pct = 23;
    write_capacity(CAP_W'($urandom_range(65534, sb.length + 4000)));
    run_random(40, 1'b0);
    wait_idle();

    // No idling at all, capacity just above the length: traffic runs up to
    // the edge of the buffer.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_capacity(CAP_W'(sb.length + $urandom_range(200, 60)));
    run_random(35, 1'b1);

    // The error is sticky and reset comes only once, so the run ends with one
    // overflow, of a kind chosen at random.
    room   = sb.room();
    ending = ending_t'($urandom_range(2));
    case (ending)
      END_HEAD_PAST_CAP: begin
        // Fill the buffer exactly, open an empty run at the edge, then a head
        // whose initial byte already falls outside.
        send_item(FUNC_RUN, 3'd0, VAL_W'(room), 8'h00);
        send_item(FUNC_RUN, 3'd0, '0, 8'h00);
        send_item(FUNC_DATA, 3'd0, '0, 8'($urandom));
        send_item(FUNC_HEAD, 3'($urandom), head_value(9), 8'h00);
      end
      END_RUN_TOO_BIG: begin
        // A run that does not fit, either by one byte or by a huge count.
        send_item(FUNC_RUN, 3'd0, ($urandom_range(1) == 0) ? VAL_W'(room + 1) :
                  {32'($urandom), 32'($urandom)}, 8'h00);
      end
      default: begin
        // Leave a few bytes so the initial byte fits but the argument does not.
        left = $urandom_range(8, 1);
        if (left > room) left = room;
        send_item(FUNC_RUN, 3'd0, VAL_W'(room - left), 8'h00);
        send_item(FUNC_HEAD, 3'($urandom), {32'($urandom_range(32'hFFFF_FFFF, 1)),
                  32'($urandom)}, 8'h00);
      end
    endcase

    // After the error heads and runs are dropped; data bytes still come out.
    send_item(FUNC_HEAD, 3'd5, 64'd7, 8'h00);
    send_item(FUNC_RUN, 3'd0, 64'd1, 8'h00);
    send_item(FUNC_DATA, 3'd0, '0, 8'h3C);
    wait_idle();

    // Zero capacity: every further data byte falls outside the buffer.
    write_capacity('0);
    repeat (6)
      send_item(FUNC_DATA, 3'($urandom), {32'($urandom), 32'($urandom)}, 8'($urandom));
    wait_idle();

    $display("Covered %0d items giving %0d byte beats (%0d stored), ended by %s,",
             sb.items_noted, sb.beats_checked, sb.beats_stored, ending.name());
    $display("across capacities from full to zero, with %0d mismatches.", sb.fail_count);
    if (sb.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
